FILE: rtl/gtra_pkg.sv
package gtra_pkg;

  localparam int RULE_WORDS_DEF    = 65536;
  localparam int NONTERMINALS_DEF  = 16384;
  localparam int START_ENTRIES_DEF = 16384;
  localparam int STACK_DEPTH_DEF   = 64;
  localparam int MAX_QUERY_DEF     = 64;
  localparam int ALPHABET          = 256;

  typedef logic [1:0] action_t;
  localparam action_t ACT_RULE_WORD = 2'd0;
  localparam action_t ACT_RULE_BASE = 2'd1;
  localparam action_t ACT_START     = 2'd2;
  localparam action_t ACT_QUERY     = 2'd3;

  typedef logic [2:0] status_t;
  localparam status_t ST_OK       = 3'd0;
  localparam status_t ST_RANGE    = 3'd1;
  localparam status_t ST_EMPTY    = 3'd2;
  localparam status_t ST_TOO_LONG = 3'd3;
  localparam status_t ST_OVERFLOW = 3'd4;

  typedef logic cfg_index_t;
  localparam cfg_index_t CFG_TEXT_LENGTH = 1'b0;
  localparam cfg_index_t CFG_START_COUNT = 1'b1;

endpackage

FILE: rtl/gtra_if.sv
interface gtra_in_if;
  logic                  valid;
  logic                  ready;
  gtra_pkg::action_t     action;
  logic [15:0]           address;
  logic [14:0]           symbol;
  logic                  end_mark;
  logic [31:0]           position;
  logic [31:0]           range_begin;
  logic [31:0]           range_end;

  modport source (output valid, action, address, symbol, end_mark, position, range_begin,
                  range_end, input ready);
  modport sink (input valid, action, address, symbol, end_mark, position, range_begin,
                range_end, output ready);
endinterface

interface gtra_out_if;
  logic                  valid;
  logic                  ready;
  logic [7:0]            character;
  logic                  last;
  gtra_pkg::status_t     status;

  modport source (output valid, character, last, status, input ready);
  modport sink (input valid, character, last, status, output ready);
endinterface

FILE: rtl/grammar_text_random_access_unit.sv
// Random-access extraction from a grammar-compressed text. Write transactions (rule word,
// rule base, start entry) give no result. A query transaction
// yields either range_end minus range_begin characters, the final one flagged last, or one
// error result with character zero and last set. A query is handled on its own: the block
// takes no new transaction until its final result has been taken. Its length is data
// dependent: it grows with the binary search steps over the start positions
// (ceil(log2(start_count + 1)) steps), with each start or rule symbol fetched, each
// nonterminal entered, each return popped at the end of a rule body and each delivered
// character, plus any wait on the result side. The rule, base, start, stack and character
// memories each have a single registered read port and are read one access at a time.
// RULE_WORDS is taken as a power of two.
module grammar_text_random_access_unit #(
  parameter int RULE_WORDS    = gtra_pkg::RULE_WORDS_DEF,
  parameter int NONTERMINALS  = gtra_pkg::NONTERMINALS_DEF,
  parameter int START_ENTRIES = gtra_pkg::START_ENTRIES_DEF,
  parameter int STACK_DEPTH   = gtra_pkg::STACK_DEPTH_DEF,
  parameter int MAX_QUERY     = gtra_pkg::MAX_QUERY_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  gtra_in_if.sink     request,
  gtra_out_if.source  result
);

  localparam int RW_AW = $clog2(RULE_WORDS);
  localparam int NT_AW = $clog2(NONTERMINALS);
  localparam int SE_AW = $clog2(START_ENTRIES);
  localparam int SEW   = $clog2(START_ENTRIES + 1);
  localparam int SAW   = $clog2(STACK_DEPTH);
  localparam int SPW   = $clog2(STACK_DEPTH + 1);
  localparam int QAW   = (MAX_QUERY > 1) ? $clog2(MAX_QUERY) : 1;
  localparam int QW    = $clog2(MAX_QUERY + 1);

  // One-hot sequencer states.
  typedef enum logic [10:0] {
    S_IDLE     = 11'b00000000001,
    S_BS_REQ   = 11'b00000000010,
    S_BS_CMP   = 11'b00000000100,
    S_FETCH    = 11'b00000001000,
    S_DECODE   = 11'b00000010000,
    S_BASE     = 11'b00000100000,
    S_POP_WORD = 11'b00001000000,
    S_POP_CHK  = 11'b00010000000,
    S_OUT_RD   = 11'b00100000000,
    S_OUT_LD   = 11'b01000000000,
    S_EMIT     = 11'b10000000000
  } state_t;

  state_t state, state_next;

  // Configuration registers.
  logic [31:0] text_length;
  logic [14:0] start_count;
  logic        cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_length <= '0;
      start_count <= '0;
    end else if (cfg_write) begin
      unique case (paddr[2])
        gtra_pkg::CFG_TEXT_LENGTH: text_length <= pwdata;
        gtra_pkg::CFG_START_COUNT: start_count <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      gtra_pkg::CFG_TEXT_LENGTH: prdata = text_length;
      gtra_pkg::CFG_START_COUNT: prdata = {17'd0, start_count};
      default:                   prdata = '0;
    endcase
  end

  // Effective number of start entries, clamped to the table depth.
  logic [SEW-1:0] count;
  assign count = ({17'd0, start_count} > 32'(START_ENTRIES)) ? SEW'(START_ENTRIES)
                                                             : SEW'(start_count);

  // Query working registers.
  logic [31:0]      q_begin, q_begin_next;
  logic [QW-1:0]    q_len, q_len_next;
  logic [SEW-1:0]   lo, lo_next, hi, hi_next, mid, mid_next;
  logic [31:0]      best_pos, best_pos_next;
  logic [SEW-1:0]   si, si_next;
  logic [31:0]      skip, skip_next;
  logic             in_rule, in_rule_next;
  logic [RW_AW-1:0] addr, addr_next;
  logic [SPW-1:0]   sp, sp_next;
  logic [QW-1:0]    emitted, emitted_next;
  logic [QW-1:0]    k, k_next;
  logic [7:0]       out_char, out_char_next;
  logic             out_last, out_last_next;
  gtra_pkg::status_t out_status, out_status_next;

  // Memory ports.
  logic             rw_we, rb_we, st_we, stk_we, buf_we;
  logic [RW_AW-1:0] rw_raddr;
  logic [15:0]      rw_rdata;
  logic [NT_AW-1:0] rb_raddr;
  logic [15:0]      rb_rdata;
  logic [SE_AW-1:0] ss_raddr, sp_raddr;
  logic [14:0]      ss_rdata;
  logic [31:0]      sp_rdata;
  logic [SAW-1:0]   stk_waddr, stk_raddr;
  logic [RW_AW-1:0] stk_rdata;
  logic [QAW-1:0]   buf_waddr, buf_raddr;
  logic [7:0]       buf_rdata;

  logic in_accept;
  assign request.ready = (state == S_IDLE);
  assign in_accept     = request.valid && request.ready;

  assign rw_we = in_accept && (request.action == gtra_pkg::ACT_RULE_WORD)
                 && ({16'd0, request.address} < 32'(RULE_WORDS));
  assign rb_we = in_accept && (request.action == gtra_pkg::ACT_RULE_BASE)
                 && ({16'd0, request.address} < 32'(NONTERMINALS));
  assign st_we = in_accept && (request.action == gtra_pkg::ACT_START)
                 && ({16'd0, request.address} < 32'(START_ENTRIES));

  // Symbol being decoded: from the start sequence or from a rule body.
  logic [14:0] dec_sym;
  logic        dec_last;
  logic [14:0] dec_nt;
  assign dec_sym  = in_rule ? rw_rdata[14:0] : ss_rdata;
  assign dec_last = in_rule && rw_rdata[15];
  assign dec_nt   = dec_sym - 15'(gtra_pkg::ALPHABET);

  assign rw_raddr  = (state == S_POP_WORD) ? stk_rdata : addr;
  assign rb_raddr  = NT_AW'(dec_nt);
  assign ss_raddr  = SE_AW'(si);
  // The probe address is presented in the cycle the midpoint is chosen, so that the
  // start position is ready when the comparison is made.
  assign sp_raddr  = SE_AW'(mid_next);
  assign stk_waddr = SAW'(sp);
  assign stk_raddr = SAW'(sp - SPW'(1));
  assign buf_waddr = QAW'(emitted);
  assign buf_raddr = QAW'(k);

  // Query checks made as the transaction is taken.
  logic [31:0] req_len;
  assign req_len = request.range_end - request.range_begin;

  always_comb begin
    state_next      = state;
    q_begin_next    = q_begin;
    q_len_next      = q_len;
    lo_next         = lo;
    hi_next         = hi;
    mid_next        = mid;
    best_pos_next   = best_pos;
    si_next         = si;
    skip_next       = skip;
    in_rule_next    = in_rule;
    addr_next       = addr;
    sp_next         = sp;
    emitted_next    = emitted;
    k_next          = k;
    out_char_next   = out_char;
    out_last_next   = out_last;
    out_status_next = out_status;
    stk_we          = 1'b0;
    buf_we          = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (in_accept && (request.action == gtra_pkg::ACT_QUERY)) begin
          q_begin_next  = request.range_begin;
          q_len_next    = QW'(req_len);
          lo_next       = '0;
          hi_next       = count;
          out_char_next = '0;
          out_last_next = 1'b1;
          if ((request.range_begin > request.range_end)
              || (request.range_end >= text_length)) begin
            out_status_next = gtra_pkg::ST_RANGE;
            state_next      = S_EMIT;
          end else if (request.range_begin == request.range_end) begin
            out_status_next = gtra_pkg::ST_EMPTY;
            state_next      = S_EMIT;
          end else if (req_len > 32'(MAX_QUERY)) begin
            out_status_next = gtra_pkg::ST_TOO_LONG;
            state_next      = S_EMIT;
          end else begin
            state_next = S_BS_REQ;
          end
        end
      end

      S_BS_REQ: begin
        if (lo < hi) begin
          mid_next   = lo + ((hi - lo) >> 1);
          state_next = S_BS_CMP;
        end else if (lo == '0) begin
          out_status_next = gtra_pkg::ST_RANGE;
          state_next      = S_EMIT;
        end else begin
          si_next      = lo - SEW'(1);
          skip_next    = q_begin - best_pos;
          in_rule_next = 1'b0;
          sp_next      = '0;
          emitted_next = '0;
          state_next   = S_FETCH;
        end
      end

      S_BS_CMP: begin
        if (sp_rdata <= q_begin) begin
          lo_next       = mid + SEW'(1);
          best_pos_next = sp_rdata;
        end else begin
          hi_next = mid;
        end
        state_next = S_BS_REQ;
      end

      S_FETCH: begin
        if (!in_rule && (si >= count)) begin
          out_status_next = gtra_pkg::ST_RANGE;
          state_next      = S_EMIT;
        end else begin
          if (!in_rule) begin
            si_next = si + SEW'(1);
          end
          state_next = S_DECODE;
        end
      end

      S_DECODE: begin
        if (dec_sym >= 15'(gtra_pkg::ALPHABET)) begin
          if ({17'd0, dec_nt} >= 32'(NONTERMINALS)) begin
            out_status_next = gtra_pkg::ST_RANGE;
            state_next      = S_EMIT;
          end else if (in_rule && (sp >= SPW'(STACK_DEPTH))) begin
            out_status_next = gtra_pkg::ST_OVERFLOW;
            state_next      = S_EMIT;
          end else begin
            if (in_rule) begin
              stk_we  = 1'b1;
              sp_next = sp + SPW'(1);
            end
            in_rule_next = 1'b1;
            state_next   = S_BASE;
          end
        end else begin
          if (skip != '0) begin
            skip_next = skip - 32'd1;
          end else begin
            buf_we       = 1'b1;
            emitted_next = emitted + QW'(1);
          end
          if ((skip == '0) && (emitted + QW'(1) == q_len)) begin
            k_next     = '0;
            state_next = S_OUT_RD;
          end else if (dec_last) begin
            if (sp == '0) begin
              in_rule_next = 1'b0;
              state_next   = S_FETCH;
            end else begin
              sp_next    = sp - SPW'(1);
              state_next = S_POP_WORD;
            end
          end else begin
            if (in_rule) begin
              addr_next = addr + RW_AW'(1);
            end
            state_next = S_FETCH;
          end
        end
      end

      S_BASE: begin
        addr_next  = RW_AW'(rb_rdata);
        state_next = S_FETCH;
      end

      // The return address has arrived; its rule word is read to see whether the
      // caller's body ends there as well.
      S_POP_WORD: begin
        addr_next  = stk_rdata;
        state_next = S_POP_CHK;
      end

      S_POP_CHK: begin
        if (rw_rdata[15]) begin
          if (sp == '0) begin
            in_rule_next = 1'b0;
            state_next   = S_FETCH;
          end else begin
            sp_next    = sp - SPW'(1);
            state_next = S_POP_WORD;
          end
        end else begin
          addr_next  = addr + RW_AW'(1);
          state_next = S_FETCH;
        end
      end

      S_OUT_RD: begin
        state_next = S_OUT_LD;
      end

      S_OUT_LD: begin
        out_char_next   = buf_rdata;
        out_last_next   = (k + QW'(1) == q_len);
        out_status_next = gtra_pkg::ST_OK;
        state_next      = S_EMIT;
      end

      S_EMIT: begin
        if (result.ready) begin
          if (out_last) begin
            state_next = S_IDLE;
          end else begin
            k_next     = k + QW'(1);
            state_next = S_OUT_RD;
          end
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sp    <= '0;
    end else begin
      state <= state_next;
      sp    <= sp_next;
    end
    q_begin    <= q_begin_next;
    q_len      <= q_len_next;
    lo         <= lo_next;
    hi         <= hi_next;
    mid        <= mid_next;
    best_pos   <= best_pos_next;
    si         <= si_next;
    skip       <= skip_next;
    in_rule    <= in_rule_next;
    addr       <= addr_next;
    emitted    <= emitted_next;
    k          <= k_next;
    out_char   <= out_char_next;
    out_last   <= out_last_next;
    out_status <= out_status_next;
  end

  assign result.valid     = (state == S_EMIT);
  assign result.character = out_char;
  assign result.last      = out_last;
  assign result.status    = out_status;

  // Rule bodies: symbol in the low fifteen bits, end mark on top.
  gtra_ram #(.WIDTH(16), .DEPTH(RULE_WORDS)) u_rule_words (
    .clk   (clk),
    .we    (rw_we),
    .waddr (RW_AW'(request.address)),
    .wdata ({request.end_mark, request.symbol}),
    .raddr (rw_raddr),
    .rdata (rw_rdata)
  );

  gtra_ram #(.WIDTH(16), .DEPTH(NONTERMINALS)) u_rule_base (
    .clk   (clk),
    .we    (rb_we),
    .waddr (NT_AW'(request.address)),
    .wdata (request.position[15:0]),
    .raddr (rb_raddr),
    .rdata (rb_rdata)
  );

  gtra_ram #(.WIDTH(15), .DEPTH(START_ENTRIES)) u_start_symbols (
    .clk   (clk),
    .we    (st_we),
    .waddr (SE_AW'(request.address)),
    .wdata (request.symbol),
    .raddr (ss_raddr),
    .rdata (ss_rdata)
  );

  gtra_ram #(.WIDTH(32), .DEPTH(START_ENTRIES)) u_start_positions (
    .clk   (clk),
    .we    (st_we),
    .waddr (SE_AW'(request.address)),
    .wdata (request.position),
    .raddr (sp_raddr),
    .rdata (sp_rdata)
  );

  // Return addresses; a push and the matching pop never fall in the same cycle.
  gtra_ram #(.WIDTH(RW_AW), .DEPTH(STACK_DEPTH)) u_return_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (addr),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // Characters of the current query, held until the query is known to succeed.
  gtra_ram #(.WIDTH(8), .DEPTH(MAX_QUERY)) u_char_buffer (
    .clk   (clk),
    .we    (buf_we),
    .waddr (buf_waddr),
    .wdata (dec_sym[7:0]),
    .raddr (buf_raddr),
    .rdata (buf_rdata)
  );

`ifndef SYNTHESIS
  a_no_result_while_idle: assert property (@(posedge clk) disable iff (rst)
    request.ready |-> !result.valid)
    else $error("result offered while the block takes transactions");

  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= SPW'(STACK_DEPTH))
    else $error("return stack pointer beyond its depth");

  a_error_shape: assert property (@(posedge clk) disable iff (rst)
    (result.valid && (result.status != gtra_pkg::ST_OK))
      |-> (result.last && (result.character == 8'd0)))
    else $error("error result without last or with a character");

  a_last_ends_query: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.ready && result.last) |=> request.ready)
    else $error("block not idle after the final result");
`endif

endmodule

FILE: rtl/gtra_ram.sv
module gtra_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
